// ----- rtl/fpsh_pkg.sv -----
// fpsh_pkg: shared types, widths and constants of the heater regulator
// used by every module of ff_pid_slew_limited_heater, no dependencies
package fpsh_pkg;

    localparam int FRAC_BITS      = 8;
    localparam int INTEGRAL_LIMIT = 80;

    localparam int TEMP_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int CAP_W     = 8;
    localparam int ERR_W     = TEMP_W + 1;
    localparam int PROD_W    = GAIN_W + ERR_W;
    localparam int FULL_W    = 2 * ERR_W;
    localparam int INC_W     = PROD_W - FRAC_BITS;
    localparam int FF_W      = TEMP_W + FRAC_BITS;
    localparam int BASE_W    = PROD_W + 2;
    localparam int RAW_W     = BASE_W + 1;
    localparam int INTEG_W   = 8 + FRAC_BITS;
    localparam int ISHIFT_W  = INTEG_W + FRAC_BITS;
    localparam int NI_W      = INC_W + 1;
    localparam int LEVEL_W   = CAP_W + FRAC_BITS;
    localparam int CAPW_W    = CAP_W + 2 * FRAC_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = INTEG_W'(INTEGRAL_LIMIT << FRAC_BITS);
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = -INTEG_MAX;
    localparam logic signed [ERR_W-1:0]   WARM_THRESH = ERR_W'(2 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT    = 3'd0,
        REG_FEEDFORWARD = 3'd1,
        REG_GAIN_P      = 3'd2,
        REG_GAIN_I      = 3'd3,
        REG_GAIN_D      = 3'd4,
        REG_SLEW_STEP   = 3'd5,
        REG_OUTPUT_CAP  = 3'd6,
        REG_HEAT_ENABLE = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } err_sign_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] setpoint;
        logic signed [TEMP_W-1:0] feedforward_counts;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
        logic [CAP_W-1:0]         slew_step;
        logic [CAP_W-1:0]         output_cap;
        logic                     heat_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        setpoint:           16'sd9728,
        feedforward_counts: 16'sd14746,
        gain_p:             16'd3584,
        gain_i:             16'd64,
        gain_d:             16'd2560,
        slew_step:          8'd4,
        output_cap:         8'd140,
        heat_enable:        1'b1
    };

    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic signed [INC_W-1:0]  inc;
        logic signed [ERR_W-1:0]  err;
        err_sign_t                sgn;
        logic                     warm;
    } item_t;

endpackage

// ----- rtl/fpsh_cfg.sv -----
// fpsh_cfg: configuration register file of the heater regulator
// depends on fpsh_pkg for the register layout and reset values
module fpsh_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fpsh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpsh_pkg::CFG_DATA_W-1:0]  cfg_data,
    output fpsh_pkg::cfg_t                   cfg
);
    import fpsh_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SETPOINT:    cfg_next.setpoint           = $signed(cfg_data[TEMP_W-1:0]);
                REG_FEEDFORWARD: cfg_next.feedforward_counts = $signed(cfg_data[TEMP_W-1:0]);
                REG_GAIN_P:      cfg_next.gain_p             = cfg_data[GAIN_W-1:0];
                REG_GAIN_I:      cfg_next.gain_i             = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:      cfg_next.gain_d             = cfg_data[GAIN_W-1:0];
                REG_SLEW_STEP:   cfg_next.slew_step          = cfg_data[CAP_W-1:0];
                REG_OUTPUT_CAP:  cfg_next.output_cap         = cfg_data[CAP_W-1:0];
                REG_HEAT_ENABLE: cfg_next.heat_enable        = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/fpsh_front.sv -----
// fpsh_front: input register, gain multipliers and drive base sum
// depends on fpsh_pkg; feeds fpsh_loop with one item_t per transfer
module fpsh_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpsh_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fpsh_pkg::TEMP_W-1:0]  sample_temp,
    output logic                                item_valid,
    input  logic                                item_ready,
    output fpsh_pkg::item_t                     item
);
    import fpsh_pkg::*;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     rdy1;
    logic                     rdy2;
    logic                     rdy3;
    logic signed [TEMP_W-1:0] prev_temp_reg;
    logic signed [TEMP_W-1:0] sample1_reg;
    logic signed [ERR_W-1:0]  dt1_reg;
    logic signed [ERR_W-1:0]  dt1_next;
    logic signed [ERR_W-1:0]  err1;
    logic signed [FULL_W-1:0] mult_p;
    logic signed [FULL_W-1:0] mult_i;
    logic signed [FULL_W-1:0] mult_d;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] d2_reg;
    logic signed [INC_W-1:0]  inc2_reg;
    logic signed [ERR_W-1:0]  err2_reg;
    logic signed [FF_W-1:0]   ff_w;
    item_t                    item_reg;
    item_t                    item_next;

    // stage readiness, each stage loads when empty or draining
    assign rdy3     = !v3_reg || item_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign dt1_next = {sample_temp[TEMP_W-1], sample_temp}
                    - {prev_temp_reg[TEMP_W-1], prev_temp_reg};

    // stage 1: error and products
    assign err1   = {cfg.setpoint[TEMP_W-1], cfg.setpoint}
                  - {sample1_reg[TEMP_W-1], sample1_reg};
    assign mult_p = FULL_W'($signed({1'b0, cfg.gain_p})) * FULL_W'(err1);
    assign mult_i = FULL_W'($signed({1'b0, cfg.gain_i})) * FULL_W'(err1);
    assign mult_d = FULL_W'($signed({1'b0, cfg.gain_d})) * FULL_W'(dt1_reg);

    // stage 2: feedforward plus proportional minus derivative
    assign ff_w = {cfg.feedforward_counts, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        item_next.base = BASE_W'(ff_w) + BASE_W'(p2_reg) - BASE_W'(d2_reg);
        item_next.inc  = inc2_reg;
        item_next.err  = err2_reg;
        item_next.warm = err2_reg > WARM_THRESH;
        if (err2_reg > 0)
        begin
            item_next.sgn = SGN_POS;
        end
        else if (err2_reg < 0)
        begin
            item_next.sgn = SGN_NEG;
        end
        else
        begin
            item_next.sgn = SGN_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            prev_temp_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (in_valid && rdy1)
            begin
                prev_temp_reg <= sample_temp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            sample1_reg <= sample_temp;
            dt1_reg     <= dt1_next;
        end
        if (rdy2)
        begin
            p2_reg   <= mult_p[PROD_W-1:0];
            d2_reg   <= mult_d[PROD_W-1:0];
            inc2_reg <= mult_i[PROD_W-1:FRAC_BITS];
            err2_reg <= err1;
        end
        if (rdy3)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = v3_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/fpsh_loop.sv -----
// fpsh_loop: integral update, drive clamp, slew limit and result register
// depends on fpsh_pkg; takes item_t from fpsh_front
module fpsh_loop (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpsh_pkg::cfg_t                      cfg,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  fpsh_pkg::item_t                     item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fpsh_pkg::CAP_W-1:0]          dac_value,
    output logic signed [fpsh_pkg::ERR_W-1:0]   error_value,
    output logic                                below_warm
);
    import fpsh_pkg::*;

    logic                       take;
    logic                       halve;
    logic                       in_window;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [INTEG_W-1:0]  integ0;
    logic signed [INTEG_W-1:0]  integ_clamp;
    logic signed [INTEG_W-1:0]  integ1;
    logic signed [ISHIFT_W-1:0] ishift0;
    logic signed [ISHIFT_W-1:0] ishift1;
    logic signed [NI_W-1:0]     ni_full;
    logic signed [RAW_W-1:0]    raw1;
    logic signed [RAW_W-1:0]    raw2;
    logic signed [CAPW_W:0]     cap_w;
    logic [CAPW_W-1:0]          drive;
    logic [LEVEL_W-1:0]         u;
    logic [LEVEL_W-1:0]         slew_w;
    logic [LEVEL_W:0]           hi;
    logic signed [LEVEL_W+1:0]  lo;
    logic [LEVEL_W-1:0]         level_reg;
    logic [LEVEL_W-1:0]         level_next;
    err_sign_t                  sgn_reg;
    err_sign_t                  sgn_next;
    logic                       out_valid_reg;
    logic [CAP_W-1:0]           dac_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic                       warm_reg;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;

    assign halve = (item.sgn == SGN_POS && sgn_reg == SGN_NEG)
                || (item.sgn == SGN_NEG && sgn_reg == SGN_POS);
    assign integ0  = halve ? (integ_reg >>> 1) : integ_reg;
    assign ishift0 = {integ0, {FRAC_BITS{1'b0}}};
    assign cap_w   = {1'b0, cfg.output_cap, {(2 * FRAC_BITS){1'b0}}};
    assign raw1    = RAW_W'(item.base) + RAW_W'(ishift0);

    assign in_window = (raw1 > 0) && (raw1 < RAW_W'(cap_w));
    assign ni_full   = NI_W'(integ0) + NI_W'(item.inc);

    always_comb
    begin
        if (ni_full > NI_W'(INTEG_MAX))
        begin
            integ_clamp = INTEG_MAX;
        end
        else if (ni_full < NI_W'(INTEG_MIN))
        begin
            integ_clamp = INTEG_MIN;
        end
        else
        begin
            integ_clamp = ni_full[INTEG_W-1:0];
        end
    end

    assign integ1  = in_window ? integ_clamp : integ0;
    assign ishift1 = {integ1, {FRAC_BITS{1'b0}}};
    assign raw2    = RAW_W'(item.base) + RAW_W'(ishift1);

    always_comb
    begin
        if (raw2 < 0)
        begin
            drive = '0;
        end
        else if (raw2 > RAW_W'(cap_w))
        begin
            drive = cap_w[CAPW_W-1:0];
        end
        else
        begin
            drive = raw2[CAPW_W-1:0];
        end
    end

    assign u      = drive[CAPW_W-1:FRAC_BITS];
    assign slew_w = {cfg.slew_step, {FRAC_BITS{1'b0}}};
    assign hi     = {1'b0, level_reg} + {1'b0, slew_w};
    assign lo     = $signed({2'b00, level_reg}) - $signed({2'b00, slew_w});

    always_comb
    begin
        integ_next = integ1;
        sgn_next   = item.sgn;
        if (!cfg.heat_enable)
        begin
            integ_next = '0;
            level_next = '0;
            sgn_next   = sgn_reg;
        end
        else if ({1'b0, u} > hi)
        begin
            level_next = hi[LEVEL_W-1:0];
        end
        else if ($signed({2'b00, u}) < lo)
        begin
            level_next = lo[LEVEL_W-1:0];
        end
        else
        begin
            level_next = u;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            level_reg     <= '0;
            sgn_reg       <= SGN_ZERO;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                integ_reg     <= integ_next;
                level_reg     <= level_next;
                sgn_reg       <= sgn_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dac_reg  <= level_next[LEVEL_W-1:FRAC_BITS];
            err_reg  <= item.err;
            warm_reg <= item.warm;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dac_value   = dac_reg;
    assign error_value = err_reg;
    assign below_warm  = warm_reg;

`ifndef SYNTHESIS
    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INTEG_MAX) && (integ_reg >= INTEG_MIN))
        else $error("integral outside its limit");

    a_slew_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cfg.heat_enable) |=>
            ({1'b0, level_reg} <= {1'b0, $past(level_reg)} + {1'b0, $past(slew_w)})
            && ({1'b0, level_reg} + {1'b0, $past(slew_w)} >= {1'b0, $past(level_reg)}))
        else $error("output moved by more than the slew step");

    a_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cfg.heat_enable) |=>
            (level_reg <= {$past(cfg.output_cap), {FRAC_BITS{1'b0}}})
            || (level_reg <= $past(level_reg)))
        else $error("output rose above the cap");

    a_disabled_off: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !cfg.heat_enable) |=>
            (dac_value == '0) && (level_reg == '0) && (integ_reg == '0))
        else $error("heater not forced off while disabled");
`endif

endmodule

// ----- rtl/ff_pid_slew_limited_heater.sv -----
// ff_pid_slew_limited_heater: feedforward pid heater regulator, top level
// depends on fpsh_pkg, fpsh_cfg, fpsh_front and fpsh_loop
//
// usage:
//   input channel in_valid/in_ready carries one signed q8.8 temperature
//   sample per transfer; output channel out_valid/out_ready returns one
//   result per sample: dac_value, error_value and below_warm
//   cfg_write/cfg_index/cfg_data writes one register per clock, no wait;
//   user must write only while no sample is in flight; block does not enforce
//   path: a sample passes the input register, multiplier register, base
//   register and result register in that order
//   throughput: one sample per cycle while the output is not stalled; the
//   integral and output level both update in the result stage
//   reset: registers return to their defaults, integral, last sample,
//   error sign and output level clear, no result is pending
//   stall: a held result does not block input; samples fill the empty
//   stages and in_ready drops only when every stage holds an item
module ff_pid_slew_limited_heater (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fpsh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpsh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fpsh_pkg::TEMP_W-1:0]  sample_temp,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fpsh_pkg::CAP_W-1:0]          dac_value,
    output logic signed [fpsh_pkg::ERR_W-1:0]   error_value,
    output logic                                below_warm
);
    import fpsh_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_ready;

    fpsh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fpsh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_temp (sample_temp),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    fpsh_loop u_loop (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dac_value   (dac_value),
        .error_value (error_value),
        .below_warm  (below_warm)
    );

endmodule

// ----- bench/ff_pid_slew_limited_heater_tb.sv -----
// ff_pid_slew_limited_heater_tb: self-checking bench for the heater regulator,
// predicts dac, error and warm flag per sample and checks every output transfer
// depends on fpsh_pkg and ff_pid_slew_limited_heater
`timescale 1ns / 100ps

module ff_pid_slew_limited_heater_tb;
    import fpsh_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        logic [CAP_W-1:0]        dac;
        logic signed [ERR_W-1:0] err;
        logic                    warm;
    } heat_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [TEMP_W-1:0] sample_temp;
    logic                     out_valid;
    logic                     out_ready;
    logic [CAP_W-1:0]         dac_value;
    logic signed [ERR_W-1:0]  error_value;
    logic                     below_warm;

    // regulator copy used for prediction
    cfg_t      heater_cfg;
    longint    integ_counts;
    longint    last_temp;
    err_sign_t last_sign;
    longint    drive_level;

    heat_result_t expected_drive[$];
    int           fail_count;
    int           quiet_cycles;
    int           hold_req;
    bit           tx_idle;
    bit           rx_idle;

    ff_pid_slew_limited_heater u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_temp (sample_temp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dac_value   (dac_value),
        .error_value (error_value),
        .below_warm  (below_warm)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void init_model();
        heater_cfg.setpoint           = 16'sd9728;
        heater_cfg.feedforward_counts = 16'sd14746;
        heater_cfg.gain_p             = 16'd3584;
        heater_cfg.gain_i             = 16'd64;
        heater_cfg.gain_d             = 16'd2560;
        heater_cfg.slew_step          = 8'd4;
        heater_cfg.output_cap         = 8'd140;
        heater_cfg.heat_enable        = 1'b1;
        integ_counts = 0;
        last_temp    = 0;
        last_sign    = SGN_ZERO;
        drive_level  = 0;
    endfunction

    function automatic heat_result_t regulate(input logic signed [TEMP_W-1:0] temp);
        heat_result_t r;
        err_sign_t    sgn;
        longint smp, err, dt, gp, gi, gd, ff_w, p_w, d_w, cap_w, lim, slew, raw, ni, u;
        smp = longint'(temp);
        err = longint'(heater_cfg.setpoint) - smp;
        r.err  = err[ERR_W-1:0];
        r.warm = (err > (longint'(2) << FRAC_BITS));
        if (!heater_cfg.heat_enable)
        begin
            integ_counts = 0;
            drive_level  = 0;
            last_temp    = smp;
            r.dac        = '0;
            return r;
        end
        sgn   = (err > 0) ? SGN_POS : (err < 0) ? SGN_NEG : SGN_ZERO;
        gp    = longint'(heater_cfg.gain_p);
        gi    = longint'(heater_cfg.gain_i);
        gd    = longint'(heater_cfg.gain_d);
        dt    = smp - last_temp;
        ff_w  = longint'(heater_cfg.feedforward_counts) * (longint'(1) << FRAC_BITS);
        p_w   = gp * err;
        d_w   = gd * dt;
        cap_w = longint'(heater_cfg.output_cap) << (2 * FRAC_BITS);
        lim   = longint'(INTEGRAL_LIMIT) << FRAC_BITS;
        slew  = longint'(heater_cfg.slew_step) << FRAC_BITS;
        if ((sgn == SGN_POS && last_sign == SGN_NEG) || (sgn == SGN_NEG && last_sign == SGN_POS))
            integ_counts = integ_counts >>> 1;
        last_sign = sgn;
        raw = ff_w + p_w + integ_counts * (longint'(1) << FRAC_BITS) - d_w;
        if (raw > 0 && raw < cap_w)
        begin
            ni = integ_counts + ((gi * err) >>> FRAC_BITS);
            if (ni > lim)
                ni = lim;
            if (ni < -lim)
                ni = -lim;
            integ_counts = ni;
        end
        raw = ff_w + p_w + integ_counts * (longint'(1) << FRAC_BITS) - d_w;
        if (raw < 0)
            raw = 0;
        if (raw > cap_w)
            raw = cap_w;
        u = raw >>> FRAC_BITS;
        if (u > drive_level + slew)
            u = drive_level + slew;
        else if (u < drive_level - slew)
            u = drive_level - slew;
        drive_level = u;
        last_temp   = smp;
        r.dac       = drive_level[2*CAP_W-1:CAP_W];
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SETPOINT:    heater_cfg.setpoint           = data;
            REG_FEEDFORWARD: heater_cfg.feedforward_counts = data;
            REG_GAIN_P:      heater_cfg.gain_p             = data;
            REG_GAIN_I:      heater_cfg.gain_i             = data;
            REG_GAIN_D:      heater_cfg.gain_d             = data;
            REG_SLEW_STEP:   heater_cfg.slew_step          = data[CAP_W-1:0];
            REG_OUTPUT_CAP:  heater_cfg.output_cap         = data[CAP_W-1:0];
            REG_HEAT_ENABLE: heater_cfg.heat_enable        = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_defaults();
        write_reg(REG_SETPOINT, 16'd9728);
        write_reg(REG_FEEDFORWARD, 16'd14746);
        write_reg(REG_GAIN_P, 16'd3584);
        write_reg(REG_GAIN_I, 16'd64);
        write_reg(REG_GAIN_D, 16'd2560);
        write_reg(REG_SLEW_STEP, 16'd4);
        write_reg(REG_OUTPUT_CAP, 16'd140);
        write_reg(REG_HEAT_ENABLE, 16'd1);
    endtask

    task automatic send_sample(input logic signed [TEMP_W-1:0] temp);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_temp <= temp;
        do
            @(posedge clk);
        while (!in_ready);
        expected_drive.push_back(regulate(temp));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain(input int unsigned typical);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, typical));
        endcase
    endfunction

    task automatic shuffle_settings();
        logic [CFG_DATA_W-1:0] v;
        logic [CAP_W-1:0]      b;
        case ($urandom_range(0, 5))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = CFG_DATA_W'($urandom);
            default: v = CFG_DATA_W'($urandom_range(20 * 256, 80 * 256));
        endcase
        write_reg(REG_SETPOINT, v);
        case ($urandom_range(0, 5))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = CFG_DATA_W'($urandom);
            default: v = CFG_DATA_W'($urandom_range(0, 100 * 256));
        endcase
        write_reg(REG_FEEDFORWARD, v);
        write_reg(REG_GAIN_P, pick_gain(8192));
        write_reg(REG_GAIN_I, pick_gain(1024));
        write_reg(REG_GAIN_D, pick_gain(8192));
        case ($urandom_range(0, 4))
            0: b = '0;
            1: b = '1;
            default: b = CAP_W'($urandom_range(1, 16));
        endcase
        write_reg(REG_SLEW_STEP, {CAP_W'($urandom), b});
        case ($urandom_range(0, 4))
            0: b = '0;
            1: b = '1;
            default: b = CAP_W'($urandom_range(60, 255));
        endcase
        write_reg(REG_OUTPUT_CAP, {CAP_W'($urandom), b});
        write_reg(REG_HEAT_ENABLE, {15'($urandom), 1'($urandom_range(0, 7) != 0)});
    endtask

    // temperature drifts around the setpoint, with occasional out-of-range readings
    task automatic run_drift(input int n_items, input int noise_pct);
        int walk;
        int k;
        logic signed [TEMP_W-1:0] smp;
        walk = int'(heater_cfg.setpoint) + int'($urandom_range(0, 2048)) - 1024;
        for (k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                smp = TEMP_W'($urandom);
            else
            begin
                walk += int'($urandom_range(0, 256)) - 128;
                if (walk > 32767)
                    walk = 32767;
                if (walk < -32768)
                    walk = -32768;
                smp = walk[TEMP_W-1:0];
            end
            send_sample(smp);
        end
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sd9728);
        send_sample(16'sd9216);
        send_sample(16'sd9215);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_GAIN_P, 16'hffff);
        write_reg(REG_GAIN_I, 16'hffff);
        write_reg(REG_GAIN_D, 16'hffff);
        write_reg(REG_SLEW_STEP, 16'hffff);
        write_reg(REG_OUTPUT_CAP, 16'hffff);
        write_reg(REG_FEEDFORWARD, 16'h7fff);
        write_reg(REG_SETPOINT, 16'h7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        drain();
        write_reg(REG_SETPOINT, 16'h8000);
        write_reg(REG_FEEDFORWARD, 16'h8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        drain();
        write_reg(REG_GAIN_P, 16'h0000);
        write_reg(REG_GAIN_I, 16'h0000);
        write_reg(REG_GAIN_D, 16'h0000);
        write_reg(REG_OUTPUT_CAP, 16'h0000);
        write_reg(REG_SLEW_STEP, 16'h0000);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        drain();
    endtask

    task automatic test_disabled_mode();
        write_defaults();
        write_reg(REG_HEAT_ENABLE, 16'd0);
        send_sample(16'sd4000);
        send_sample(16'sd9728);
        drain();
        write_reg(REG_HEAT_ENABLE, 16'd1);
        send_sample(16'sd9000);
        drain();
    endtask

    // integral builds up, then error sign flips both ways, then passes through zero
    task automatic test_sign_flip_halving();
        write_defaults();
        send_sample(16'sd8704);
        send_sample(16'sd8704);
        send_sample(16'sd10752);
        send_sample(16'sd8704);
        send_sample(16'sd9728);
        send_sample(16'sd9984);
        drain();
    endtask

    task automatic test_cap_below_level();
        write_reg(REG_OUTPUT_CAP, 16'd255);
        write_reg(REG_SLEW_STEP, 16'd255);
        send_sample(16'sd0);
        drain();
        write_reg(REG_OUTPUT_CAP, 16'd10);
        write_reg(REG_SLEW_STEP, 16'd4);
        repeat (4) send_sample(16'sd0);
        drain();
    endtask

    task automatic test_random_settings();
        int p;
        for (p = 0; p < 12; p++)
        begin
            shuffle_settings();
            run_drift(100, (p % 3 == 0) ? 40 : 8);
            drain();
        end
    endtask

    task automatic test_output_backpressure();
        write_defaults();
        tx_idle  = 1'b0;
        hold_req = 48;
        run_drift(30, 5);
        drain();
        tx_idle = 1'b1;
    endtask

    task automatic test_full_rate();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        shuffle_settings();
        write_reg(REG_HEAT_ENABLE, 16'd1);
        run_drift(100, 5);
        drain();
    endtask

    task automatic finish_run();
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    endtask

    // receiver: random stall bursts, plus a long hold when requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
                out_ready <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        heat_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_drive.size() == 0)
            begin
                $error("unexpected result transfer: dac_value %0d error_value %0d",
                       dac_value, error_value);
                fail_count++;
            end
            else
            begin
                exp_r = expected_drive.pop_front();
                if (dac_value !== exp_r.dac)
                begin
                    $error("dac_value expected %0d got %0d", exp_r.dac, dac_value);
                    fail_count++;
                end
                if (error_value !== exp_r.err)
                begin
                    $error("error_value expected %0d got %0d", exp_r.err, error_value);
                    fail_count++;
                end
                if (below_warm !== exp_r.warm)
                begin
                    $error("below_warm expected %0d got %0d", exp_r.warm, below_warm);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        sample_temp  = '0;
        fail_count   = 0;
        quiet_cycles = 0;
        hold_req     = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        init_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_disabled_mode();
        test_sign_flip_halving();
        test_cap_below_level();
        test_random_settings();
        test_output_backpressure();
        test_full_rate();
        finish_run();
    end

endmodule
